// ===== hdl/nbl_pkg.sv =====
// Shared types, constants and saturation helpers for the leapfrog integrator.
`default_nettype none
package nbl_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int MAX_BODIES_DEF  = 64;
	localparam int CFG_IW          = 2;
	localparam int CFG_DW          = 31;

	localparam logic [CFG_IW-1:0] REG_GRAV  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_TSCL  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_SOFT  = 2'd2;
	localparam logic [CFG_IW-1:0] REG_SUBST = 2'd3;

	localparam logic [30:0] GRAV_RST  = 31'd327680000;
	localparam logic [30:0] TSCL_RST  = 31'd131072;
	localparam logic [30:0] SOFT_RST  = 31'd655;
	localparam logic [3:0]  SUBST_RST = 4'd3;

	localparam logic [63:0] CAP62    = 64'h4000_0000_0000_0000;
	localparam logic [63:0] INT64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ACC_MAX  = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] TERM_MAX = 64'h0000_0100_0000_0000;
	localparam logic [63:0] H_MAX    = 64'h0000_0000_7FFF_FFFF;

	typedef enum logic [4:0] {
		S_LOAD, S_HMUL, S_HGO, S_HWAIT, S_CLR, S_NRD, S_NLAT, S_MRD, S_MLAT,
		S_MGO, S_MWAIT, S_SGO, S_SWAIT, S_DGO, S_DWAIT, S_MWR, S_NWR,
		S_URD, S_ULAT, S_UWR, S_ORD, S_OLAT, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_FORCE0, PH_KICKH, PH_DRIFT, PH_FORCE, PH_KICK, PH_KICKN
	} phase_t;

	typedef enum logic [3:0] {
		M_DX, M_DY, M_DEN, M_FMM, M_FMN, M_TNX, M_TNY, M_TMX, M_TMY, M_UX, M_UY
	} mop_t;

	// acc +/- term, term below 2^47, saturated to signed 48 bits
	function automatic logic signed [47:0] addsat48(input logic signed [47:0] acc,
			input logic [63:0] term, input logic neg);
		logic signed [48:0] t;
		logic signed [48:0] s;
		begin
			t = {2'b00, term[46:0]};
			s = {acc[47], acc} + (neg ? -t : t);
			if (s > 49'sh0_7FFF_FFFF_FFFF)
				addsat48 = 48'sh7FFF_FFFF_FFFF;
			else if (s < -49'sh0_8000_0000_0000)
				addsat48 = 48'sh8000_0000_0000;
			else
				addsat48 = s[47:0];
		end
	endfunction

	// base +/- term, term at most 2^40, saturated to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [31:0] base,
			input logic [63:0] term, input logic neg);
		logic signed [42:0] t;
		logic signed [42:0] s;
		begin
			t = {2'b00, term[40:0]};
			s = {{11{base[31]}}, base} + (neg ? -t : t);
			if (s > 43'sh000_7FFF_FFFF)
				sat32 = 32'sh7FFF_FFFF;
			else if (s < -43'sh000_8000_0000)
				sat32 = 32'sh8000_0000;
			else
				sat32 = s[31:0];
		end
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		begin
			mag48 = v[47] ? 48'(-v) : 48'(v);
		end
	endfunction

endpackage
`default_nettype wire

// ===== hdl/nbl_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module nbl_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [W-1:0]               wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [W-1:0]              rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/nbl_mul.sv =====
// 64x64 unsigned multiply from four 32x32 partial products, >> FRAC_BITS, capped.
`default_nettype none
module nbl_mul (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] a,
	input  wire  [63:0] b,
	input  wire  [63:0] lim,
	output logic        done,
	output logic [63:0] res
);
	import nbl_pkg::*;

	logic [63:0]  a_q, b_q, lim_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [1:0]   psh_s1;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  ah, bh;
	logic [127:0] pp_sh, shr;

	always_comb begin
		ah = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		bh = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		unique case (psh_s1)
			2'd0:    pp_sh = {64'd0, pp_s1};
			2'd1:    pp_sh = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_sh = {pp_s1, 64'd0};
			default: pp_sh = '0;
		endcase
		shr  = acc_q >> FRAC_BITS;
		res  = (shr > {64'd0, lim_q}) ? lim_q : shr[63:0];
		done = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			lim_q <= lim;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= 3'd3) begin
				pp_s1  <= {32'd0, ah} * {32'd0, bh};
				psh_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_sh;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/nbl_sqrt.sv =====
// Bit-serial integer root: floor(sqrt(d << FRAC_BITS)), two radicand bits per cycle.
`default_nettype none
module nbl_sqrt (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] d,
	output logic        done,
	output logic [63:0] root
);
	import nbl_pkg::*;

	logic [127:0] x_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;
	logic [67:0]  rem_sh, trial;
	logic         take;

	always_comb begin
		rem_sh = {rem_q, x_q[127:126]};
		trial  = {2'b00, root_q, 2'b01};
		take   = rem_sh >= trial;
		done   = done_q;
		root   = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= {64'd0, d} << FRAC_BITS;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[125:0], 2'b00};
			if (take) begin
				rem_q  <= 66'(rem_sh - trial);
				root_q <= {root_q[62:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[65:0];
				root_q <= {root_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/nbl_div.sv =====
// Restoring 64/64 unsigned divider, one quotient bit per cycle.
`default_nettype none
module nbl_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] num,
	input  wire  [63:0] den,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] q_q, den_q;
	logic [64:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] rem_sh;
	logic        take;

	always_comb begin
		rem_sh = {rem_q[63:0], q_q[63]};
		take   = rem_sh >= {1'b0, den_q};
		done   = done_q;
		quo    = q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
			q_q   <= {q_q[62:0], take};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/nbody_leapfrog_integrator.sv =====
// Top level: body RAMs, run sequencer and shared arithmetic units of the integrator.
//
// Usage:
//   Bodies stream in on s_axis, one word per body; tlast marks the final body and its
//   frame_dt sets the substep h = (time_scale*frame_dt >> 16) / substeps. Bodies past
//   MAX_BODIES are dropped, but their tlast still starts the run.
//   Configuration registers are written through cfg_we/cfg_idx/cfg_data while idle.
//   After the run, one word per body leaves on m_axis in load order, tlast on the last.
// Run sequence:
//   While loading, s_axis_tready stays high, so a body is taken whenever offered.
//   A run is a force pass, a half kick, substeps rounds of drift/force/kick, and a
//   final half kick. Each body pair takes nine passes through the shared multiplier,
//   a root and a divide (no divide when the denominator is zero); a kick or drift
//   takes two multiplier passes per body. A run has (substeps+1) force passes and
//   (2*substeps+2) update passes, after h is formed by a multiply and a divide.
//   The block works on one frame at a time; s_axis_tready is low during the run.
// Reset and stall:
//   arst_n clears the sequencer and the registers to their defaults; body RAMs hold
//   garbage until loaded. A stalled m_axis holds the output word until taken;
//   with no stall, each result word steps through S_ORD, S_OLAT and S_OUT before the next.
`default_nettype none
module nbody_leapfrog_integrator #(
	parameter int MAX_BODIES = nbl_pkg::MAX_BODIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// fields from bit 0: mass[30:0], pos_x[62:31], pos_y[94:63], vel_x[126:95],
	// vel_y[158:127], frame_dt[178:159], zero pad
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [183:0]                 s_axis_tdata,
	input  wire                          s_axis_tlast,
	// fields from bit 0: body_index[5:0], new_pos_x[37:6], new_pos_y[69:38],
	// new_vel_x[101:70], new_vel_y[133:102], zero pad
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [135:0]                 m_axis_tdata,
	output logic                         m_axis_tlast,
	input  wire                          cfg_we,
	input  wire  [nbl_pkg::CFG_IW-1:0]   cfg_idx,
	input  wire  [nbl_pkg::CFG_DW-1:0]   cfg_data
);
	import nbl_pkg::*;

	localparam int AW  = $clog2(MAX_BODIES);
	localparam int CW  = $clog2(MAX_BODIES + 1);
	localparam int CW1 = CW + 1;

	// configuration
	logic [30:0] grav_q, tscl_q, soft_q;
	logic [3:0]  subst_q;

	// sequencer
	state_t state_q, state_d, pd_state;
	phase_t phase_q, ph_nx;
	mop_t   mop_q;
	logic [CW-1:0] cnt_q, nb_q, i_q, n_q, m_q;
	logic [CW1-1:0] i_inc, m_inc, n_inc2;
	logic [3:0]  rnd_q, rounds_q;
	logic        last_rnd, phase_done, clr_last;

	// datapath registers
	logic [19:0]  fdt_q;
	logic [50:0]  prod_s1;
	logic [30:0]  h_q;
	logic signed [31:0] pxn_q, pyn_q;
	logic [30:0]  mn_q, mm_q;
	logic signed [47:0] accn_x_q, accn_y_q, accm_x_q, accm_y_q;
	logic [32:0]  dxm_q, dym_q;
	logic         dx_neg_q, dy_neg_q;
	logic [63:0]  sqx_q, d_q, root_q, den_q, factor_q, fmm_q, fmn_q;
	logic signed [31:0] basex_q, basey_q, newx_q, newy_q;
	logic [47:0]  opx_q, opy_q;
	logic         opx_neg_q, opy_neg_q;
	logic [5:0]   o_idx_q;
	logic [31:0]  o_px_q, o_py_q, o_vx_q, o_vy_q;
	logic         o_last_q;

	// input fields
	logic [30:0] in_mass;
	logic [31:0] in_px, in_py, in_vx, in_vy;
	logic [19:0] in_fdt;
	logic        in_acc, room;

	// memories
	logic          we_body, we_pos, we_vel, we_acc;
	logic [AW-1:0] waddr, raddr;
	logic [30:0]   mass_rd;
	logic [31:0]   px_rd, py_rd, vx_rd, vy_rd, px_wd, py_wd, vx_wd, vy_wd;
	logic [47:0]   ax_rd, ay_rd, ax_wd, ay_wd;

	// arithmetic units
	logic        mul_start, mul_done, sq_start, sq_done, div_start, div_done;
	logic [63:0] mul_a, mul_b, mul_lim, mul_res, sq_root, div_num, div_den, div_q;
	logic [30:0] coef_mag;
	logic        coef_neg;
	logic signed [32:0] dx, dy;

	assign in_mass = s_axis_tdata[30:0];
	assign in_px   = s_axis_tdata[62:31];
	assign in_py   = s_axis_tdata[94:63];
	assign in_vx   = s_axis_tdata[126:95];
	assign in_vy   = s_axis_tdata[158:127];
	assign in_fdt  = s_axis_tdata[178:159];

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign room    = cnt_q < CW'(MAX_BODIES);

	assign i_inc   = CW1'(i_q) + CW1'(1);
	assign m_inc   = CW1'(m_q) + CW1'(1);
	assign n_inc2  = CW1'(n_q) + CW1'(2);
	assign last_rnd = ({1'b0, rnd_q} + 5'd1) == {1'b0, rounds_q};
	assign clr_last = i_inc == CW1'(nb_q);

	assign coef_mag = (phase_q == PH_KICKH || phase_q == PH_KICKN) ? {1'b0, h_q[30:1]} : h_q;
	assign coef_neg = phase_q == PH_KICKN;

	assign dx = {pxn_q[31], pxn_q} - {px_rd[31], px_rd};
	assign dy = {pyn_q[31], pyn_q} - {py_rd[31], py_rd};

	// where the sequencer goes when a pass over the bodies ends
	always_comb begin
		unique case (phase_q)
			PH_FORCE0: begin ph_nx = PH_KICKH; pd_state = S_URD; end
			PH_KICKH:  begin ph_nx = PH_DRIFT; pd_state = S_URD; end
			PH_DRIFT:  begin ph_nx = PH_FORCE; pd_state = S_CLR; end
			PH_FORCE:  begin ph_nx = PH_KICK;  pd_state = S_URD; end
			PH_KICK: begin
				ph_nx    = last_rnd ? PH_KICKN : PH_DRIFT;
				pd_state = S_URD;
			end
			PH_KICKN:  begin ph_nx = PH_KICKN; pd_state = S_ORD; end
			default:   begin ph_nx = PH_FORCE0; pd_state = S_LOAD; end
		endcase
	end

	always_comb begin
		phase_done = ((state_q == S_CLR) && clr_last && (nb_q < CW'(2)))
			|| ((state_q == S_NWR) && !(n_inc2 < CW1'(nb_q)))
			|| ((state_q == S_UWR) && !(i_inc < CW1'(nb_q)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:  if (in_acc && s_axis_tlast) state_d = S_HMUL;
			S_HMUL:  state_d = S_HGO;
			S_HGO:   state_d = S_HWAIT;
			S_HWAIT: if (div_done) state_d = S_CLR;
			S_CLR: begin
				if (clr_last)
					state_d = (nb_q < CW'(2)) ? pd_state : S_NRD;
			end
			S_NRD:   state_d = S_NLAT;
			S_NLAT:  state_d = S_MRD;
			S_MRD:   state_d = S_MLAT;
			S_MLAT:  state_d = S_MGO;
			S_MGO:   state_d = S_MWAIT;
			S_MWAIT: begin
				if (mul_done) begin
					unique case (mop_q)
						M_DY:    state_d = S_SGO;
						M_DEN:   state_d = (mul_res == 64'd0) ? S_MGO : S_DGO;
						M_TMY:   state_d = S_MWR;
						M_UY:    state_d = S_UWR;
						default: state_d = S_MGO;
					endcase
				end
			end
			S_SGO:   state_d = S_SWAIT;
			S_SWAIT: if (sq_done) state_d = S_MGO;
			S_DGO:   state_d = S_DWAIT;
			S_DWAIT: if (div_done) state_d = S_MGO;
			S_MWR:   state_d = (m_inc < CW1'(nb_q)) ? S_MRD : S_NWR;
			S_NWR:   state_d = (n_inc2 < CW1'(nb_q)) ? S_NRD : pd_state;
			S_URD:   state_d = S_ULAT;
			S_ULAT:  state_d = S_MGO;
			S_UWR:   state_d = (i_inc < CW1'(nb_q)) ? S_URD : pd_state;
			S_ORD:   state_d = S_OLAT;
			S_OLAT:  state_d = S_OUT;
			S_OUT: begin
				if (m_axis_tready)
					state_d = clr_last ? S_LOAD : S_ORD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// outputs of the sequencer: handshakes, memory ports, unit starts and operands
	always_comb begin
		s_axis_tready = state_q == S_LOAD;
		m_axis_tvalid = state_q == S_OUT;
		we_body   = (state_q == S_LOAD) && in_acc && room;
		we_pos    = (state_q == S_UWR) && (phase_q == PH_DRIFT);
		we_vel    = (state_q == S_UWR) && (phase_q != PH_DRIFT);
		we_acc    = (state_q == S_CLR) || (state_q == S_MWR) || (state_q == S_NWR);
		mul_start = state_q == S_MGO;
		sq_start  = state_q == S_SGO;
		div_start = (state_q == S_HGO) || (state_q == S_DGO);

		unique case (state_q)
			S_LOAD:  waddr = cnt_q[AW-1:0];
			S_MWR:   waddr = m_q[AW-1:0];
			S_NWR:   waddr = n_q[AW-1:0];
			default: waddr = i_q[AW-1:0];
		endcase
		unique case (state_q)
			S_NRD:   raddr = n_q[AW-1:0];
			S_MRD:   raddr = m_q[AW-1:0];
			default: raddr = i_q[AW-1:0];
		endcase

		px_wd = (state_q == S_LOAD) ? in_px : newx_q;
		py_wd = (state_q == S_LOAD) ? in_py : newy_q;
		vx_wd = (state_q == S_LOAD) ? in_vx : newx_q;
		vy_wd = (state_q == S_LOAD) ? in_vy : newy_q;
		unique case (state_q)
			S_MWR:   begin ax_wd = accm_x_q; ay_wd = accm_y_q; end
			S_NWR:   begin ax_wd = accn_x_q; ay_wd = accn_y_q; end
			default: begin ax_wd = '0;       ay_wd = '0;       end
		endcase

		if (state_q == S_HGO) begin
			div_num = 64'(prod_s1 >> FRAC_BITS);
			div_den = 64'(rounds_q);
		end else begin
			div_num = {33'd0, grav_q} << FRAC_BITS;
			div_den = den_q;
		end

		unique case (mop_q)
			M_DX:    begin mul_a = 64'(dxm_q);    mul_b = 64'(dxm_q);  mul_lim = CAP62;    end
			M_DY:    begin mul_a = 64'(dym_q);    mul_b = 64'(dym_q);  mul_lim = CAP62;    end
			M_DEN:   begin mul_a = d_q;           mul_b = root_q;      mul_lim = INT64MAX; end
			M_FMM:   begin mul_a = factor_q;      mul_b = 64'(mm_q);   mul_lim = CAP62;    end
			M_FMN:   begin mul_a = factor_q;      mul_b = 64'(mn_q);   mul_lim = CAP62;    end
			M_TNX:   begin mul_a = fmm_q;         mul_b = 64'(dxm_q);  mul_lim = ACC_MAX;  end
			M_TNY:   begin mul_a = fmm_q;         mul_b = 64'(dym_q);  mul_lim = ACC_MAX;  end
			M_TMX:   begin mul_a = fmn_q;         mul_b = 64'(dxm_q);  mul_lim = ACC_MAX;  end
			M_TMY:   begin mul_a = fmn_q;         mul_b = 64'(dym_q);  mul_lim = ACC_MAX;  end
			M_UX:    begin mul_a = 64'(coef_mag); mul_b = 64'(opx_q);  mul_lim = TERM_MAX; end
			M_UY:    begin mul_a = 64'(coef_mag); mul_b = 64'(opy_q);  mul_lim = TERM_MAX; end
			default: begin mul_a = '0;            mul_b = '0;          mul_lim = '0;       end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			phase_q  <= PH_FORCE0;
			mop_q    <= M_DX;
			cnt_q    <= '0;
			nb_q     <= '0;
			i_q      <= '0;
			n_q      <= '0;
			m_q      <= '0;
			rnd_q    <= '0;
			rounds_q <= 4'd1;
			grav_q   <= GRAV_RST;
			tscl_q   <= TSCL_RST;
			soft_q   <= SOFT_RST;
			subst_q  <= SUBST_RST;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_GRAV:  grav_q  <= cfg_data;
					REG_TSCL:  tscl_q  <= cfg_data;
					REG_SOFT:  soft_q  <= cfg_data;
					REG_SUBST: subst_q <= cfg_data[3:0];
					default:   ;
				endcase
			end

			if (state_q == S_LOAD && in_acc) begin
				if (room)
					cnt_q <= cnt_q + CW'(1);
				if (s_axis_tlast) begin
					nb_q     <= room ? cnt_q + CW'(1) : cnt_q;
					rounds_q <= (subst_q == 4'd0) ? 4'd1 : subst_q;
				end
			end

			if (state_q == S_HWAIT && div_done) begin
				phase_q <= PH_FORCE0;
				i_q     <= '0;
			end

			// body index returns to zero at the end of every pass
			if (state_q == S_CLR) begin
				i_q <= clr_last ? '0 : CW'(i_inc);
				n_q <= '0;
			end
			if (state_q == S_NLAT)
				m_q <= n_q + CW'(1);
			if (state_q == S_MWR)
				m_q <= CW'(m_inc);
			if (state_q == S_NWR)
				n_q <= n_q + CW'(1);
			if (state_q == S_UWR)
				i_q <= phase_done ? '0 : CW'(i_inc);

			if (state_q == S_MLAT)
				mop_q <= M_DX;
			if (state_q == S_ULAT)
				mop_q <= M_UX;
			if (state_q == S_SWAIT && sq_done)
				mop_q <= M_DEN;
			if (state_q == S_MWAIT && mul_done) begin
				unique case (mop_q)
					M_DX:    mop_q <= M_DY;
					M_DEN:   mop_q <= M_FMM;
					M_FMM:   mop_q <= M_FMN;
					M_FMN:   mop_q <= M_TNX;
					M_TNX:   mop_q <= M_TNY;
					M_TNY:   mop_q <= M_TMX;
					M_TMX:   mop_q <= M_TMY;
					M_UX:    mop_q <= M_UY;
					default: mop_q <= mop_q;
				endcase
			end

			// pass bookkeeping; round count steps after each full kick
			if (phase_done) begin
				phase_q <= ph_nx;
				if (phase_q == PH_KICKH)
					rnd_q <= '0;
				else if (phase_q == PH_KICK)
					rnd_q <= rnd_q + 4'd1;
			end

			if (state_q == S_OUT && m_axis_tready) begin
				if (clr_last) begin
					cnt_q <= '0;
					i_q   <= '0;
				end else begin
					i_q <= CW'(i_inc);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && in_acc && s_axis_tlast)
			fdt_q <= in_fdt;
		if (state_q == S_HMUL)
			prod_s1 <= {20'd0, tscl_q} * {31'd0, fdt_q};
		if (state_q == S_HWAIT && div_done)
			h_q <= (div_q > H_MAX) ? H_MAX[30:0] : div_q[30:0];

		if (state_q == S_NLAT) begin
			pxn_q    <= px_rd;
			pyn_q    <= py_rd;
			mn_q     <= mass_rd;
			accn_x_q <= ax_rd;
			accn_y_q <= ay_rd;
		end
		if (state_q == S_MLAT) begin
			mm_q     <= mass_rd;
			accm_x_q <= ax_rd;
			accm_y_q <= ay_rd;
			dx_neg_q <= dx[32];
			dy_neg_q <= dy[32];
			dxm_q    <= dx[32] ? 33'(-dx) : 33'(dx);
			dym_q    <= dy[32] ? 33'(-dy) : 33'(dy);
		end
		if (state_q == S_ULAT) begin
			if (phase_q == PH_DRIFT) begin
				basex_q   <= px_rd;
				basey_q   <= py_rd;
				opx_q     <= mag48({{16{vx_rd[31]}}, vx_rd});
				opy_q     <= mag48({{16{vy_rd[31]}}, vy_rd});
				opx_neg_q <= vx_rd[31];
				opy_neg_q <= vy_rd[31];
			end else begin
				basex_q   <= vx_rd;
				basey_q   <= vy_rd;
				opx_q     <= mag48(ax_rd);
				opy_q     <= mag48(ay_rd);
				opx_neg_q <= ax_rd[47];
				opy_neg_q <= ay_rd[47];
			end
		end

		if (state_q == S_SWAIT && sq_done)
			root_q <= sq_root;
		if (state_q == S_DWAIT && div_done)
			factor_q <= (div_q > CAP62) ? CAP62 : div_q;

		if (state_q == S_MWAIT && mul_done) begin
			unique case (mop_q)
				M_DX:  sqx_q <= mul_res;
				M_DY:  d_q   <= sqx_q + mul_res + {33'd0, soft_q};
				M_DEN: begin
					den_q <= mul_res;
					// zero denominator: factor takes its cap
					if (mul_res == 64'd0)
						factor_q <= CAP62;
				end
				M_FMM: fmm_q <= mul_res;
				M_FMN: fmn_q <= mul_res;
				M_TNX: accn_x_q <= addsat48(accn_x_q, mul_res, !dx_neg_q);
				M_TNY: accn_y_q <= addsat48(accn_y_q, mul_res, !dy_neg_q);
				M_TMX: accm_x_q <= addsat48(accm_x_q, mul_res, dx_neg_q);
				M_TMY: accm_y_q <= addsat48(accm_y_q, mul_res, dy_neg_q);
				M_UX:  newx_q <= sat32(basex_q, mul_res, coef_neg ^ opx_neg_q);
				M_UY:  newy_q <= sat32(basey_q, mul_res, coef_neg ^ opy_neg_q);
				default: ;
			endcase
		end

		if (state_q == S_OLAT) begin
			o_idx_q  <= 6'(i_q);
			o_px_q   <= px_rd;
			o_py_q   <= py_rd;
			o_vx_q   <= vx_rd;
			o_vy_q   <= vy_rd;
			o_last_q <= clr_last;
		end
	end

	assign m_axis_tdata = {2'b00, o_vy_q, o_vx_q, o_py_q, o_px_q, o_idx_q};
	assign m_axis_tlast = o_last_q;

	nbl_ram #(.W(31), .DEPTH(MAX_BODIES)) u_mass (
		.clk(clk), .we(we_body), .waddr(waddr), .wdata(in_mass),
		.raddr(raddr), .rdata(mass_rd)
	);
	nbl_ram #(.W(32), .DEPTH(MAX_BODIES)) u_px (
		.clk(clk), .we(we_body || we_pos), .waddr(waddr), .wdata(px_wd),
		.raddr(raddr), .rdata(px_rd)
	);
	nbl_ram #(.W(32), .DEPTH(MAX_BODIES)) u_py (
		.clk(clk), .we(we_body || we_pos), .waddr(waddr), .wdata(py_wd),
		.raddr(raddr), .rdata(py_rd)
	);
	nbl_ram #(.W(32), .DEPTH(MAX_BODIES)) u_vx (
		.clk(clk), .we(we_body || we_vel), .waddr(waddr), .wdata(vx_wd),
		.raddr(raddr), .rdata(vx_rd)
	);
	nbl_ram #(.W(32), .DEPTH(MAX_BODIES)) u_vy (
		.clk(clk), .we(we_body || we_vel), .waddr(waddr), .wdata(vy_wd),
		.raddr(raddr), .rdata(vy_rd)
	);
	nbl_ram #(.W(48), .DEPTH(MAX_BODIES)) u_ax (
		.clk(clk), .we(we_acc), .waddr(waddr), .wdata(ax_wd),
		.raddr(raddr), .rdata(ax_rd)
	);
	nbl_ram #(.W(48), .DEPTH(MAX_BODIES)) u_ay (
		.clk(clk), .we(we_acc), .waddr(waddr), .wdata(ay_wd),
		.raddr(raddr), .rdata(ay_rd)
	);

	nbl_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.lim(mul_lim), .done(mul_done), .res(mul_res)
	);
	nbl_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .d(d_q),
		.done(sq_done), .root(sq_root)
	);
	nbl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_q)
	);
endmodule
`default_nettype wire

// ===== tb/tb_nbody_leapfrog_integrator.sv =====
// Testbench for the 2D softened-gravity leapfrog integrator: stream stimulus, predictor, checks.
`timescale 1ns / 1ps

typedef struct {
	bit [30:0] mass;
	bit [31:0] px, py, vx, vy;
	bit [19:0] dt;
	bit        last;
} body_word_t;

typedef struct {
	bit [5:0]  idx;
	bit [31:0] px, py, vx, vy;
	bit        last;
} state_word_t;

// Predicts each frame from the bodies loaded so far and checks the result words in order.
class leapfrog_predictor;
	localparam int NB = 64;
	localparam bit [63:0] CAP62 = 64'h4000_0000_0000_0000;
	localparam bit [63:0] I64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam bit [63:0] ACCMAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam bit [63:0] TERMMAX = 64'h0000_0100_0000_0000;

	bit [63:0] grav = 327680000, tscale = 131072, eps_sq = 655, nsub = 3;
	bit [63:0] mass[NB];
	longint px[NB], py[NB], vx[NB], vy[NB], ax[NB], ay[NB];
	int loaded;
	state_word_t expected_bodies[$];
	int errors, mismatches, results_seen, frames_done;

	function void set_reg(bit [1:0] idx, bit [30:0] val);
		case (idx)
			nbl_pkg::REG_GRAV:  grav = 64'(val);
			nbl_pkg::REG_TSCL:  tscale = 64'(val);
			nbl_pkg::REG_SOFT:  eps_sq = 64'(val);
			nbl_pkg::REG_SUBST: nsub = 64'(val[3:0]);
		endcase
	endfunction

	function int pending();
		return expected_bodies.size();
	endfunction

	// min((a*b) >> 16, lim), exact product
	function bit [63:0] mulsh(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
		bit [127:0] p;
		p = ({64'b0, a} * {64'b0, b}) >> 16;
		return (p > {64'b0, lim}) ? lim : p[63:0];
	endfunction

	function bit [63:0] umag(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function longint smul(longint a, longint b, bit [63:0] lim);
		bit [63:0] m;
		m = mulsh(umag(a), umag(b), lim);
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// floor(sqrt(d * 2^16)), bit-pair method
	function bit [63:0] root_q(bit [63:0] d);
		bit [127:0] x, rem, root, trial;
		x = {64'b0, d} << 16;
		rem = 0;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((x >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[63:0];
	endfunction

	function void acc_add(ref longint acc, input bit [63:0] c, input bit neg);
		longint v;
		v = neg ? -longint'(c) : longint'(c);
		acc = clamp(acc + v, -longint'(ACCMAX) - 1, longint'(ACCMAX));
	endfunction

	function void forces(int n_b);
		longint dx, dy;
		bit [63:0] d, den, f, fm_m, fm_n;
		for (int n = 0; n < n_b; n++) begin
			ax[n] = 0;
			ay[n] = 0;
		end
		for (int n = 0; n < n_b; n++)
			for (int m = n + 1; m < n_b; m++) begin
				dx = px[n] - px[m];
				dy = py[n] - py[m];
				d = mulsh(umag(dx), umag(dx), CAP62) + mulsh(umag(dy), umag(dy), CAP62)
					+ eps_sq;
				den = mulsh(d, root_q(d), I64MAX);
				f = CAP62;
				if (den != 0) begin
					f = (grav << 16) / den;
					if (f > CAP62) f = CAP62;
				end
				fm_m = mulsh(f, mass[m], CAP62);
				fm_n = mulsh(f, mass[n], CAP62);
				acc_add(ax[n], mulsh(fm_m, umag(dx), ACCMAX), dx >= 0);
				acc_add(ay[n], mulsh(fm_m, umag(dy), ACCMAX), dy >= 0);
				acc_add(ax[m], mulsh(fm_n, umag(dx), ACCMAX), dx < 0);
				acc_add(ay[m], mulsh(fm_n, umag(dy), ACCMAX), dy < 0);
			end
	endfunction

	function void kick(int n_b, longint c);
		for (int n = 0; n < n_b; n++) begin
			vx[n] = clamp(vx[n] + smul(c, ax[n], TERMMAX), -64'sd2147483648, 64'sd2147483647);
			vy[n] = clamp(vy[n] + smul(c, ay[n], TERMMAX), -64'sd2147483648, 64'sd2147483647);
		end
	endfunction

	function void drift(int n_b, longint h);
		for (int n = 0; n < n_b; n++) begin
			px[n] = clamp(px[n] + smul(h, vx[n], TERMMAX), -64'sd2147483648, 64'sd2147483647);
			py[n] = clamp(py[n] + smul(h, vy[n], TERMMAX), -64'sd2147483648, 64'sd2147483647);
		end
	endfunction

	// one accepted input word; the last one runs the whole frame
	function void note_body(body_word_t b);
		int rounds;
		bit [63:0] h;
		state_word_t o;
		if (loaded < NB) begin
			mass[loaded] = 64'(b.mass);
			px[loaded] = longint'(signed'(b.px));
			py[loaded] = longint'(signed'(b.py));
			vx[loaded] = longint'(signed'(b.vx));
			vy[loaded] = longint'(signed'(b.vy));
			loaded++;
		end
		if (!b.last) return;
		rounds = (nsub == 0) ? 1 : int'(nsub);
		h = ((tscale * b.dt) >> 16) / rounds;
		if (h > 64'h7FFF_FFFF) h = 64'h7FFF_FFFF;
		forces(loaded);
		kick(loaded, longint'(h >> 1));
		for (int i = 0; i < rounds; i++) begin
			drift(loaded, longint'(h));
			forces(loaded);
			kick(loaded, longint'(h));
		end
		kick(loaded, -longint'(h >> 1));
		for (int k = 0; k < loaded; k++) begin
			o.idx = k[5:0];
			o.px = px[k][31:0];
			o.py = py[k][31:0];
			o.vx = vx[k][31:0];
			o.vy = vy[k][31:0];
			o.last = (k == loaded - 1);
			expected_bodies.insert(expected_bodies.size(), o);
		end
		loaded = 0;
		frames_done++;
	endfunction

	function void check_body(state_word_t got);
		state_word_t e;
		results_seen++;
		if (expected_bodies.size() == 0) begin
			errors++;
			if (mismatches++ < 10)
				$display("unexpected result word: idx %0d", got.idx);
			return;
		end
		e = expected_bodies.pop_front();
		if (got != e) begin
			errors++;
			if (mismatches++ < 10)
				$display("mismatch idx exp %0d got %0d | px %h/%h py %h/%h vx %h/%h vy %h/%h last %b/%b",
					e.idx, got.idx, e.px, got.px, e.py, got.py, e.vx, got.vx,
					e.vy, got.vy, e.last, got.last);
		end
	endfunction
endclass

module tb_nbody_leapfrog_integrator;
	import nbl_pkg::*;

	localparam int WATCHDOG = 3_000_000;	// cycles with no handshake
	localparam int LONG_HOLD = 3000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// from bit 0: mass, pos_x, pos_y, vel_x, vel_y, frame_dt, zero pad
	logic [183:0] s_axis_tdata = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// from bit 0: body_index, new_pos_x, new_pos_y, new_vel_x, new_vel_y, zero pad
	logic [135:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_idx = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	leapfrog_predictor sb = new();

	bit quiet = 0;        // no idling near the end
	bit hold_armed = 0;   // receiver takes one long hold-off when set
	int items_sent = 0;
	int cfg_changes = 0;
	int quiet_cycles = 0;

	nbody_leapfrog_integrator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// monitor: both handshakes plus the no-progress watchdog
	always @(posedge clk) begin
		body_word_t bw;
		state_word_t sw;
		if (arst_n) begin
			quiet_cycles++;
			if (s_axis_tvalid && s_axis_tready) begin
				bw.mass = s_axis_tdata[30:0];
				bw.px = s_axis_tdata[62:31];
				bw.py = s_axis_tdata[94:63];
				bw.vx = s_axis_tdata[126:95];
				bw.vy = s_axis_tdata[158:127];
				bw.dt = s_axis_tdata[178:159];
				bw.last = s_axis_tlast;
				sb.note_body(bw);
				quiet_cycles = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sw.idx = m_axis_tdata[5:0];
				sw.px = m_axis_tdata[37:6];
				sw.py = m_axis_tdata[69:38];
				sw.vx = m_axis_tdata[101:70];
				sw.vy = m_axis_tdata[133:102];
				sw.last = m_axis_tlast;
				sb.check_body(sw);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= WATCHDOG) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	always @(posedge clk) begin
		static int hold_cnt = 0;
		static int stall_cnt = 0;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (hold_armed && m_axis_tvalid) begin
			hold_armed <= 1'b0;
			hold_cnt = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_cnt = $urandom_range(1, 11) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// offer one word and hold it until taken; may leave a gap after it
	task automatic send_word(body_word_t b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, b.dt, b.vy, b.vx, b.py, b.px, b.mass};
		s_axis_tlast <= b.last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// idle point: sender stops until every expected word is out, then the block settles;
	// the pending count is read only after the monitor has noted the last word
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// block must be idle; writes all four registers back to back
	task automatic set_config(bit [30:0] g, bit [30:0] t, bit [30:0] s, bit [3:0] n);
		bit [30:0] vals[4];
		vals = '{g, t, s, {27'b0, n}};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IW'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(CFG_IW'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		cfg_changes++;
	endtask

	function automatic bit [31:0] rand_signed(int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// plausible body: moderate mass, position and velocity; otherwise all bits random
	function automatic body_word_t make_body(bit sane);
		body_word_t b;
		if (sane) begin
			b.mass = 31'($urandom_range(0, 32'h0064_0000));
			b.px = rand_signed(32'h0064_0000);
			b.py = rand_signed(32'h0064_0000);
			b.vx = rand_signed(32'h000A_0000);
			b.vy = rand_signed(32'h000A_0000);
			b.dt = 20'($urandom_range(32'h0400, 32'h4000));
		end else begin
			b.mass = 31'($urandom());
			b.px = $urandom();
			b.py = $urandom();
			b.vx = $urandom();
			b.vy = $urandom();
			b.dt = 20'($urandom());
		end
		b.last = 1'b0;
		return b;
	endfunction

	task automatic send_frame(int n, bit sane);
		body_word_t b;
		for (int i = 0; i < n; i++) begin
			b = make_body(sane);
			b.last = (i == n - 1);
			send_word(b);
		end
	endtask

	initial begin
		body_word_t b;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: reset defaults, ordinary pair
		send_frame(2, 1);
		drain();

		// lone body, no pairs; extreme mass, position, velocity and frame time
		b = '{31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			20'hF_FFFF, 1'b1};
		send_word(b);
		drain();

		// coincident bodies with no softening: denominator truncates to zero
		set_config(31'd327680000, 31'd131072, 31'd0, 4'd2);
		b = '{31'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 20'h0, 1'b0};
		send_word(b);
		b = '{31'h0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 20'h800, 1'b1};
		send_word(b);
		drain();

		// register extremes, zero substeps treated as one
		set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 4'd0);
		send_frame(3, 0);
		drain();
		set_config(31'd0, 31'd0, 31'd0, 4'd15);
		send_frame(2, 1);
		drain();

		// opposite corners, full-scale velocities
		set_config(31'd327680000, 31'd131072, 31'd655, 4'd1);
		b = '{31'h0064_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			20'h1000, 1'b0};
		send_word(b);
		b = '{31'h0064_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			20'h1000, 1'b1};
		send_word(b);
		drain();

		// store full: 65 bodies, the extra one dropped but its mark starts the run
		set_config(31'd327680000, 31'd131072, 31'd655, 4'd1);
		send_frame(65, 1);
		drain();

		// random frames, mostly well-formed
		set_config(31'd327680000, 31'd131072, 31'd655, 4'd3);
		for (int f = 0; items_sent < 140; f++) begin
			if (items_sent > 125) quiet = 1;
			if (f % 4 == 3) begin
				drain();
				case ($urandom_range(0, 3))
					0: set_config(31'($urandom()), 31'($urandom()), 31'($urandom()),
						4'($urandom_range(0, 15)));
					1: set_config(31'd327680000, 31'd131072, 31'd655,
						4'($urandom_range(0, 4)));
					default: set_config(31'($urandom_range(0, 32'h2000_0000)),
						31'($urandom_range(32'h8000, 32'h4_0000)),
						31'($urandom_range(0, 32'h1_0000)), 4'($urandom_range(1, 5)));
				endcase
			end
			// long receiver hold while the next frame is already being offered
			if (f == 2) hold_armed <= 1'b1;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 5);
			send_frame(n, $urandom_range(0, 4) != 0);
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d body words in %0d frames, %0d state words checked, %0d register sets",
			items_sent, sb.frames_done, sb.results_seen, cfg_changes);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d words still expected", sb.errors, sb.pending());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/nbl_pkg.sv
hdl/nbl_ram.sv
hdl/nbl_mul.sv
hdl/nbl_sqrt.sv
hdl/nbl_div.sv
hdl/nbody_leapfrog_integrator.sv
tb/tb_nbody_leapfrog_integrator.sv
